### rtl/core/modbus_rtu_frame_parser_top_assert.svh
// Assertion macros used by the frame parser checker.
// Depends on nothing; included by the checker file.
`ifndef MODBUS_RTU_FRAME_PARSER_TOP_ASSERT_SVH
`define MODBUS_RTU_FRAME_PARSER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define MRFP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define MRFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/mrfp_pkg.sv
// Shared widths, constants and result type of the Modbus RTU frame parser.
// Depends on nothing.
`timescale 1ns / 1ps

package mrfp_pkg;

  localparam int DATA_W      = 8;
  localparam int CNT_W       = 4;
  localparam int CRC_W       = 16;
  localparam int PAYLOAD_W   = 64;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 104;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_READ_LEN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_LEN = 1'd1;

  localparam logic [CFG_DATA_W-1:0] READ_LEN_RST  = 4'd1;
  localparam logic [CFG_DATA_W-1:0] WRITE_LEN_RST = 4'd4;

  localparam logic [DATA_W-1:0] FC_READ_HOLDING = 8'h03;
  localparam logic [DATA_W-1:0] FC_READ_INPUT   = 8'h04;
  localparam logic [DATA_W-1:0] FC_WRITE_SINGLE = 8'h06;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic                 crc_ok;
    logic [CRC_W-1:0]     received_crc;
    logic [PAYLOAD_W-1:0] payload;
    logic [CNT_W-1:0]     data_count;
    logic [DATA_W-1:0]    function_code;
    logic [DATA_W-1:0]    slave_addr;
  } mrfp_result_t;

endpackage

### rtl/core/modbus_rtu_frame_parser_top.sv
// Top level of the Modbus RTU frame parser: input register, config registers,
// frame walker and result register. Depends on mrfp_pkg, mrfp_frame_fsm, mrfp_out_reg.
`timescale 1ns / 1ps

// Modbus RTU frame parser. Feed one received byte per item on the in_ channel:
// address, function code, data bytes, then the CRC low byte and high byte.
// Function codes 0x03 and 0x04 take read_len data bytes, 0x06 takes write_len
// (a length of zero counts as one, above MAX_DATA it saturates); any other
// code drops the frame and the next byte starts a new frame as its address.
// After the CRC high byte one item leaves on the out_ channel with the address,
// function code, data count, packed data, received CRC and a CRC-match flag.
// The CRC-16 (seed 0xFFFF, reflected poly 0xA001) runs over address, function
// and data bytes. Rate: one byte per clock unless a result stalls in the output
// register. Each byte is held in the input register, then the byte-wide CRC network
// and frame walker update the state in one step; out_tvalid rises in the cycle after
// the walker takes the last byte of a frame, which needs a free output register.
// in_tready drops only while a result waits in the output register and the input
// register is full. Write read_len (index 0) and write_len (index 1) between frames;
// a frame uses the length latched when its function code was taken.

module modbus_rtu_frame_parser_top #(
  parameter int MAX_DATA = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: rx_byte[7:0]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mrfp_pkg::IN_TDATA_W-1:0]   in_tdata,
  // out_tdata: slave_addr[7:0], function_code[15:8], data_count[19:16],
  // payload[83:20], received_crc[99:84], crc_ok[100], zero[103:101]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mrfp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_we,
  input  logic [mrfp_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [mrfp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import mrfp_pkg::*;

  logic                  stage_valid_r, stage_valid_nxt;
  logic [DATA_W-1:0]     stage_byte_r;
  logic [CFG_DATA_W-1:0] read_len_r, read_len_nxt;
  logic [CFG_DATA_W-1:0] write_len_r, write_len_nxt;
  logic                  out_free;
  logic                  step;
  logic                  res_valid;
  mrfp_result_t          res;

  // Advance the input register whenever its byte can be consumed.
  assign in_tready = !stage_valid_r || out_free;
  assign step      = stage_valid_r && out_free;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (in_tready) begin
      stage_valid_nxt = in_tvalid;
    end
  end

  always_comb begin
    read_len_nxt  = read_len_r;
    write_len_nxt = write_len_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_READ_LEN:  read_len_nxt  = cfg_wdata;
        REG_WRITE_LEN: write_len_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      read_len_r    <= READ_LEN_RST;
      write_len_r   <= WRITE_LEN_RST;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      read_len_r    <= read_len_nxt;
      write_len_r   <= write_len_nxt;
    end
  end

  // Hold the byte until the frame walker takes it.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stage_byte_r <= in_tdata[DATA_W-1:0];
    end
  end

  mrfp_frame_fsm #(
    .MAX_DATA (MAX_DATA)
  ) u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (stage_byte_r),
    .read_len  (read_len_r),
    .write_len (write_len_r),
    .res_valid (res_valid),
    .res       (res)
  );

  mrfp_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### rtl/core/mrfp_crc16.sv
// Byte-wide CRC-16 update, reflected polynomial, LSB first.
// Depends on mrfp_pkg.
`timescale 1ns / 1ps

module mrfp_crc16 (
  input  logic [mrfp_pkg::CRC_W-1:0]  crc_in,
  input  logic [mrfp_pkg::DATA_W-1:0] data_in,
  output logic [mrfp_pkg::CRC_W-1:0]  crc_out
);
  import mrfp_pkg::*;

  always_comb begin
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-DATA_W){1'b0}}, data_in};
    for (int k = 0; k < DATA_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

### rtl/core/mrfp_frame_fsm.sv
// Frame walker: phase control, running CRC, data capture and result forming.
// Depends on mrfp_pkg and mrfp_crc16.
`timescale 1ns / 1ps

module mrfp_frame_fsm #(
  parameter int MAX_DATA = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  logic [mrfp_pkg::DATA_W-1:0]     rx_byte,
  input  logic [mrfp_pkg::CFG_DATA_W-1:0] read_len,
  input  logic [mrfp_pkg::CFG_DATA_W-1:0] write_len,
  output logic                            res_valid,
  output mrfp_pkg::mrfp_result_t          res
);
  import mrfp_pkg::*;

  localparam int IDX_W = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DATA);

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_FUNC   = 5'b00010,
    PH_DATA   = 5'b00100,
    PH_CRC_LO = 5'b01000,
    PH_CRC_HI = 5'b10000
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [DATA_W-1:0]  addr_r, addr_nxt;
  logic [DATA_W-1:0]  func_r, func_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   target_r, target_nxt;
  logic [CRC_W-1:0]   crc_r, crc_nxt;
  logic [DATA_W-1:0]  crc_lo_r, crc_lo_nxt;
  logic [DATA_W-1:0]  store_r [MAX_DATA];
  logic               store_we;

  logic [CRC_W-1:0]   crc_base;
  logic [CRC_W-1:0]   crc_fed;
  logic [CRC_W-1:0]   rx_crc;
  logic [CNT_W-1:0]   count_inc;

  function automatic logic [CNT_W-1:0] clamp_len(input logic [CFG_DATA_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = CNT_W'(v);
    if (r == '0) begin
      r = CNT_W'(1);
    end else if (r > MAX_CNT) begin
      r = MAX_CNT;
    end
    return r;
  endfunction

  // An address byte always restarts the CRC from its seed.
  assign crc_base = (phase_r == PH_FUNC || phase_r == PH_DATA) ? crc_r : CRC_INIT;

  mrfp_crc16 u_crc (
    .crc_in  (crc_base),
    .data_in (rx_byte),
    .crc_out (crc_fed)
  );

  assign rx_crc    = {rx_byte, crc_lo_r};
  assign count_inc = count_r + CNT_W'(1);

  always_comb begin
    phase_nxt  = phase_r;
    addr_nxt   = addr_r;
    func_nxt   = func_r;
    count_nxt  = count_r;
    target_nxt = target_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    store_we   = 1'b0;
    res_valid  = 1'b0;
    if (step) begin
      unique case (phase_r)
        PH_FUNC: begin
          func_nxt  = rx_byte;
          count_nxt = '0;
          case (rx_byte) inside
            FC_READ_HOLDING, FC_READ_INPUT: begin
              target_nxt = clamp_len(read_len);
              crc_nxt    = crc_fed;
              phase_nxt  = PH_DATA;
            end
            FC_WRITE_SINGLE: begin
              target_nxt = clamp_len(write_len);
              crc_nxt    = crc_fed;
              phase_nxt  = PH_DATA;
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
        PH_DATA: begin
          store_we  = (count_r < MAX_CNT);
          count_nxt = count_inc;
          crc_nxt   = crc_fed;
          if (count_inc >= target_r) begin
            phase_nxt = PH_CRC_LO;
          end
        end
        PH_CRC_LO: begin
          crc_lo_nxt = rx_byte;
          phase_nxt  = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          res_valid = 1'b1;
          phase_nxt = PH_IDLE;
        end
        default: begin
          addr_nxt  = rx_byte;
          crc_nxt   = crc_fed;
          phase_nxt = PH_FUNC;
        end
      endcase
    end
  end

  always_comb begin
    res               = '0;
    res.slave_addr    = addr_r;
    res.function_code = func_r;
    res.data_count    = count_r;
    res.received_crc  = rx_crc;
    res.crc_ok        = (crc_r == rx_crc);
    for (int i = 0; i < MAX_DATA; i++) begin
      if (CNT_W'(i) < count_r) begin
        res.payload[DATA_W*i +: DATA_W] = store_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      addr_r   <= '0;
      func_r   <= '0;
      count_r  <= '0;
      target_r <= '0;
      crc_r    <= CRC_INIT;
      crc_lo_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      addr_r   <= addr_nxt;
      func_r   <= func_nxt;
      count_r  <= count_nxt;
      target_r <= target_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  // Data bytes need no reset: only bytes written in the current frame are read.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[count_r[IDX_W-1:0]] <= rx_byte;
    end
  end

endmodule

### rtl/core/mrfp_out_reg.sv
// Result register of the frame parser with stream handshake and packing.
// Depends on mrfp_pkg.
`timescale 1ns / 1ps

module mrfp_out_reg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               res_valid,
  input  mrfp_pkg::mrfp_result_t             res,
  output logic                               free,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mrfp_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import mrfp_pkg::*;

  localparam int RES_W = $bits(mrfp_result_t);

  logic         valid_r, valid_nxt;
  mrfp_result_t data_r;

  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (free) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free && res_valid) begin
      data_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, data_r};

endmodule

### rtl/core/mrfp_checker.sv
// Port-level checks of the frame parser, bound to the top level.
// Depends on mrfp_pkg and modbus_rtu_frame_parser_top_assert.svh.
`timescale 1ns / 1ps
`include "modbus_rtu_frame_parser_top_assert.svh"

module mrfp_checker #(
  parameter int MAX_DATA = 8
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [mrfp_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [mrfp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                              cfg_we,
  input logic [mrfp_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input logic [mrfp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import mrfp_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DATA);

  logic [CNT_W-1:0]  out_count;
  logic [DATA_W-1:0] out_func;
  logic              cfg_unused;

  assign out_count  = out_tdata[19:16];
  assign out_func   = out_tdata[15:8];
  assign cfg_unused = cfg_we ^ (^cfg_addr) ^ (^cfg_wdata) ^ in_tvalid ^ (^in_tdata);

  `MRFP_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")
  `MRFP_ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> !out_tvalid, "result valid right after reset")
  `MRFP_ASSERT(a_stall_cause, clk, rst_n, !in_tready |-> out_tvalid && !out_tready, "input stalled with output free")
  `MRFP_ASSERT(a_res_fields, clk, rst_n, out_tvalid |-> out_count != '0 && out_count <= MAX_CNT && (out_func == FC_READ_HOLDING || out_func == FC_READ_INPUT || out_func == FC_WRITE_SINGLE) && !(cfg_unused && 1'b0), "result fields out of range")

endmodule

bind modbus_rtu_frame_parser_top mrfp_checker #(.MAX_DATA(MAX_DATA)) u_mrfp_checker (.*);
